// ===== rtl/tccs_pkg.sv =====
// shared types and constants of the text console cursor scroller
package tccs_pkg;

    localparam int SCREENS_IN_BUFFER = 2;
    localparam int NUM_SLOTS         = 8;
    localparam int CMD_W             = 41;
    localparam int OUT_TDATA_W       = 48;

    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_END_ESC = 8'd109;
    localparam logic [7:0] CH_FIRST   = 8'd32;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [6:0] GLYPH_SP   = 7'd32;

    localparam logic [7:0] COLUMNS_RST = 8'd40;
    localparam logic [6:0] ROWS_RST    = 7'd30;

    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TOP   = 2'd2
    } t_cmd_code;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] top_row;
        logic [7:0] span_end;
        logic [7:0] cell_row;
        logic [7:0] cell_column;
        logic [6:0] glyph;
        t_cmd_code  cmd;
    } t_cmd;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] widest;
        logic       skip;
    } t_state;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        t_cmd [NUM_SLOTS-1:0] slot;
        t_state               nxt;
    } t_step;

endpackage

// ===== rtl/tccs_step.sv =====
// per character decode: command slots and next cursor state
module tccs_step
    import tccs_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic [7:0] i_columns,
    input  logic [6:0] i_rows,
    input  t_state     i_state,
    output t_step      o_step
);

    logic [7:0] w_mirror_from;
    logic [7:0] w_buffer_rows;
    logic [7:0] w_rows8;
    logic       w_print;
    logic       w_bs;
    logic       w_wrap;
    logic       w_mirror;
    logic       w_scroll;
    logic       w_end;
    logic [7:0] w_col1;
    logic [7:0] w_col2;
    logic [7:0] w_col3;
    logic [7:0] w_col4;
    logic [7:0] w_row4;
    logic [7:0] w_row5;
    logic [7:0] w_wid1;

    always_comb begin
        w_rows8       = {1'b0, i_rows};
        w_mirror_from = 8'(w_rows8 * (SCREENS_IN_BUFFER - 1)) + 8'd1;
        w_buffer_rows = 8'(w_rows8 * SCREENS_IN_BUFFER);
        w_mirror      = i_state.row >= w_mirror_from;

        w_print = (i_char >= CH_FIRST) && (i_char < CH_DEL);
        w_col1  = w_print ? i_state.col + 8'd1 : i_state.col;
        w_bs    = (i_char == CH_BS) && (w_col1 > 8'd1);
        w_col2  = w_bs ? w_col1 - 8'd1 : w_col1;
        w_col3  = (i_char == CH_CR) ? 8'd0 : w_col2;
        w_wrap  = (w_col3 == i_columns) || (i_char == CH_LF);
        w_wid1  = (w_wrap && (w_col3 > i_state.widest)) ? w_col3 : i_state.widest;
        w_col4  = w_wrap ? 8'd0 : w_col3;
        w_row4  = w_wrap ? i_state.row + 8'd1 : i_state.row;
        w_scroll = w_row4 >= w_rows8;
        w_end    = w_row4 == w_buffer_rows;
        w_row5   = w_end ? w_rows8 - 8'd1 : w_row4;

        // all fields zero, command draw
        o_step.slot = '0;
        o_step.mask = '0;

        // glyph draw or backspace erase
        o_step.slot[0].cmd         = CMD_DRAW;
        o_step.slot[0].glyph       = w_bs ? GLYPH_SP : i_char[6:0];
        o_step.slot[0].cell_column = w_bs ? w_col2 : i_state.col;
        o_step.slot[0].cell_row    = i_state.row;
        o_step.mask[0]             = w_print || w_bs;

        o_step.slot[1].cmd         = CMD_DRAW;
        o_step.slot[1].glyph       = i_char[6:0];
        o_step.slot[1].cell_column = i_state.col;
        o_step.slot[1].cell_row    = i_state.row - w_mirror_from;
        o_step.mask[1]             = w_print && w_mirror;

        // line end clears
        o_step.slot[2].cmd         = CMD_CLEAR;
        o_step.slot[2].cell_column = w_col3;
        o_step.slot[2].cell_row    = i_state.row;
        o_step.slot[2].span_end    = w_wid1;
        o_step.mask[2]             = w_wrap;

        o_step.slot[3].cmd         = CMD_CLEAR;
        o_step.slot[3].cell_column = w_col3;
        o_step.slot[3].cell_row    = i_state.row - w_mirror_from;
        o_step.slot[3].span_end    = w_wid1;
        o_step.mask[3]             = w_wrap && w_mirror;

        // scroll
        o_step.slot[4].cmd     = CMD_TOP;
        o_step.slot[4].top_row = w_row4 - w_rows8 + 8'd1;
        o_step.mask[4]         = w_scroll;

        o_step.slot[5].cmd      = CMD_CLEAR;
        o_step.slot[5].cell_row = w_row4;
        o_step.slot[5].span_end = w_wid1;
        o_step.mask[5]          = w_scroll && (w_col4 == 8'd0);

        // buffer wrap back to first screen
        o_step.slot[6].cmd      = CMD_CLEAR;
        o_step.slot[6].cell_row = w_row5;
        o_step.slot[6].span_end = w_wid1;
        o_step.mask[6]          = w_end && (w_col4 == 8'd0);

        o_step.slot[7].cmd = CMD_TOP;
        o_step.mask[7]     = w_end;

        o_step.nxt.col    = w_col4;
        o_step.nxt.row    = w_row5;
        o_step.nxt.widest = w_wid1;
        o_step.nxt.skip   = i_char == CH_ESC;

        if (i_state.skip) begin
            o_step.mask     = '0;
            o_step.nxt      = i_state;
            o_step.nxt.skip = i_char != CH_END_ESC;
        end
    end

endmodule

// ===== rtl/text_console_cursor_scroller.sv =====
// top level: cursor state, command slot register and output sequencing
// the first command of a character appears in the cycle after it is accepted
// throughput: one character per cycle when it yields at most one command and m_axis_tready is high,
//   otherwise its commands (up to eight) go out lowest slot first, set by the output slot sequencer
// a character is accepted in the cycle its predecessor's last command is taken
// reset (synchronous, active low): cursor, widest column and escape flag cleared,
//   columns 40, rows 30, no commands pending
module text_console_cursor_scroller
    import tccs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [7:0]             i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // char_code
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cmd, glyph, cell_column, cell_row, span_end, top_row, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic [7:0]           r_columns;
    logic [6:0]           r_rows;
    t_state               r_state;
    logic [NUM_SLOTS-1:0] r_mask;
    logic [NUM_SLOTS-1:0] n_mask;
    t_cmd [NUM_SLOTS-1:0] r_slot;
    t_step                w_step;
    logic [2:0]           w_idx;
    logic [NUM_SLOTS-1:0] w_low;
    logic                 w_single;
    logic                 w_in_acc;
    logic                 w_out_acc;

    tccs_step u_step (
        .i_char    (s_axis_tdata),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .i_state   (r_state),
        .o_step    (w_step)
    );

    always_comb begin
        w_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = 3'(i);
            end
        end
        w_low    = r_mask & (~r_mask + NUM_SLOTS'(1));
        w_single = (r_mask & (r_mask - NUM_SLOTS'(1))) == '0;

        m_axis_tvalid = r_mask != '0;
        m_axis_tlast  = w_single;
        m_axis_tdata  = OUT_TDATA_W'(r_slot[w_idx]);
        s_axis_tready = (r_mask == '0) || (w_single && m_axis_tready);
        w_in_acc      = s_axis_tvalid && s_axis_tready;
        w_out_acc     = m_axis_tvalid && m_axis_tready;

        n_mask = r_mask;
        if (w_out_acc) begin
            n_mask = r_mask & ~w_low;
        end
        if (w_in_acc) begin
            n_mask = w_step.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RST;
            r_rows    <= ROWS_RST;
            r_state   <= '0;
            r_mask    <= '0;
        end else begin
            r_mask <= n_mask;
            if (w_in_acc) begin
                r_state <= w_step.nxt;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_COLUMNS: r_columns <= i_cfg_wdata;
                    REG_ROWS:    r_rows    <= i_cfg_wdata[6:0];
                    default:     r_columns <= r_columns;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_slot <= w_step.slot;
        end
    end

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_state.skip) |=> !m_axis_tvalid)
        else $error("escape-skipped item produced a command");

    a_print_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_state.skip && s_axis_tdata >= CH_FIRST && s_axis_tdata < CH_DEL)
        |=> (m_axis_tvalid && m_axis_tdata[1:0] == CMD_DRAW))
        else $error("printable item gave no draw command");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no pending command");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_state))
        else $error("cursor state changed without an item");

endmodule
